[sv/binary_rectangle_extent_max_macros.svh]
// ----------------------------------------------------------------------------
// binary_rectangle_extent_max assertion macros
// shared property forms for the checker, sampled on i_clk, idle in reset
// ----------------------------------------------------------------------------
`ifndef BINARY_RECTANGLE_EXTENT_MAX_MACROS_SVH
`define BINARY_RECTANGLE_EXTENT_MAX_MACROS_SVH

// same-cycle implication
`define BREMX_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BREMX_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bremx_pkg.sv]
// ----------------------------------------------------------------------------
// bremx_pkg
// shared constants, register codes and control bundles of the extent finder
// ----------------------------------------------------------------------------
package bremx_pkg;

    // default image bounds
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0] CNT_RST = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } t_cfg_reg;

    // result field widths
    localparam int OUT_WID_W  = 7;
    localparam int OUT_HGT_W  = 7;
    localparam int OUT_AREA_W = 13;
    localparam int OUT_POS_W  = 6;

    // pixel pipeline control toward the tracker
    typedef struct packed {
        logic accept;   // input beat taken into stage one
        logic advance;  // stage one moves on, its updates commit
    } t_pipe_ctl;

    // control toward the running-best units
    typedef struct packed {
        logic load;     // capture new candidates
        logic update;   // fold candidates into the best
        logic flush;    // last pixel: best goes out and restarts
    } t_best_ctl;

endpackage

[sv/bremx_track.sv]
// ----------------------------------------------------------------------------
// bremx_track
// raster position, column and run tracking, candidate generation per pixel
// ----------------------------------------------------------------------------
module bremx_track
    import bremx_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int RW  = $clog2(MAX_ROWS),
    localparam int CW  = $clog2(MAX_COLS),
    localparam int RHW = $clog2(MAX_ROWS + 1),
    localparam int CHW = $clog2(MAX_COLS + 1),
    localparam int AW  = $clog2(MAX_ROWS * MAX_COLS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_row_count,
    input  logic [CFG_W-1:0] i_col_count,
    input  t_pipe_ctl        i_ctl,
    input  logic             i_pixel,
    output logic             o_last,
    output logic [CHW-1:0]   o_w_val,
    output logic [RW-1:0]    o_w_row,
    output logic [CW-1:0]    o_w_col,
    output logic [RHW-1:0]   o_h_val,
    output logic [RW-1:0]    o_h_row,
    output logic [CW-1:0]    o_h_col,
    output logic [AW-1:0]    o_a_val,
    output logic [RW-1:0]    o_a_row,
    output logic [CW-1:0]    o_a_col,
    output logic [AW-1:0]    o_b_val,
    output logic [RW-1:0]    o_b_row,
    output logic [CW-1:0]    o_b_col
);

    localparam int KR = (RHW > CFG_W) ? RHW : CFG_W;
    localparam int KC = (CHW > CFG_W) ? CHW : CFG_W;
    localparam int PW = CHW + RHW;

    // column memories: corner row with height, and run width
    logic [RW+RHW-1:0] mem_rh [MAX_COLS];
    logic [CHW-1:0]    mem_w  [MAX_COLS];

    logic [RHW-1:0] rows;
    logic [CHW-1:0] cols;
    logic           col_end;
    logic           row_end;

    logic [RW-1:0]  r_row_pos;
    logic [CW-1:0]  r_col_pos;

    logic           r_s1_pix;
    logic [RW-1:0]  r_s1_r;
    logic [CW-1:0]  r_s1_c;
    logic           r_s1_lc;
    logic           r_s1_lr;
    logic [RW+RHW-1:0] r_rd_rh;
    logic [CHW-1:0] r_rd_w;

    logic [MAX_COLS-1:0] r_act;
    logic [MAX_COLS-1:0] r_upper;
    logic           r_left;
    logic           r_run_act;
    logic [CHW-1:0] r_run_w;
    logic [CW-1:0]  r_run_c;

    logic [RW-1:0]  rd_row;
    logic [RHW-1:0] rd_h;

    logic           s1_act;
    logic           s1_up;
    logic           s1_left;
    logic           s1_start;
    logic           s1_col_inc;
    logic [RHW-1:0] s1_h_inc;
    logic [PW-1:0]  s1_prod;
    logic [AW-1:0]  s1_area;
    logic           s1_rinc;
    logic           s1_run_on;
    logic [CHW-1:0] s1_run_w;
    logic [CW-1:0]  s1_run_c;
    logic           s1_rclose;

    logic              wr_rh_en;
    logic [RW+RHW-1:0] wr_rh_data;
    logic              wr_w_en;

    // counts held to 1..max
    always_comb begin
        if (i_row_count == '0) begin
            rows = RHW'(1);
        end else if (KR'(i_row_count) > KR'(MAX_ROWS)) begin
            rows = RHW'(MAX_ROWS);
        end else begin
            rows = RHW'(i_row_count);
        end
        if (i_col_count == '0) begin
            cols = CHW'(1);
        end else if (KC'(i_col_count) > KC'(MAX_COLS)) begin
            cols = CHW'(MAX_COLS);
        end else begin
            cols = CHW'(i_col_count);
        end
    end

    assign col_end = (CHW'(r_col_pos) + CHW'(1)) >= cols;
    assign row_end = (RHW'(r_row_pos) + RHW'(1)) >= rows;

    // raster position of the next beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (i_ctl.accept) begin
            if (col_end) begin
                r_col_pos <= '0;
                r_row_pos <= row_end ? '0 : r_row_pos + RW'(1);
            end else begin
                r_col_pos <= r_col_pos + CW'(1);
            end
        end
    end

    // column memories with a bypass for the write from stage one
    always_ff @(posedge i_clk) begin
        if (wr_rh_en) begin
            mem_rh[r_s1_c] <= wr_rh_data;
        end
        if (wr_w_en) begin
            mem_w[s1_run_c] <= s1_run_w;
        end
        if (i_ctl.accept) begin
            r_s1_pix <= i_pixel;
            r_s1_r   <= r_row_pos;
            r_s1_c   <= r_col_pos;
            r_s1_lc  <= col_end;
            r_s1_lr  <= row_end;
            r_rd_rh  <= (wr_rh_en && (r_s1_c == r_col_pos)) ? wr_rh_data
                                                           : mem_rh[r_col_pos];
            r_rd_w   <= (wr_w_en && (s1_run_c == r_col_pos)) ? s1_run_w
                                                            : mem_w[r_col_pos];
        end
    end

    assign {rd_row, rd_h} = r_rd_rh;
    assign o_last = r_s1_lc && r_s1_lr;

    // stage one: region start, column and run bookkeeping
    always_comb begin
        s1_act     = r_act[r_s1_c];
        s1_up      = (r_s1_r != '0) && r_upper[r_s1_c];
        s1_left    = (r_s1_c != '0) && r_left;
        s1_start   = r_s1_pix && !s1_up && !s1_left;
        s1_col_inc = s1_act && r_s1_pix && !s1_start;
        s1_h_inc   = rd_h + RHW'(1);
        s1_prod    = PW'(r_rd_w) * PW'(s1_h_inc);
        s1_area    = s1_prod[AW-1:0];
        s1_rinc    = r_run_act && r_s1_pix;
        s1_run_on  = s1_start || s1_rinc;
        if (s1_start) begin
            s1_run_w = CHW'(1);
        end else if (s1_rinc) begin
            s1_run_w = r_run_w + CHW'(1);
        end else begin
            s1_run_w = r_run_w;
        end
        s1_run_c   = s1_start ? r_s1_c : r_run_c;
        s1_rclose  = (r_run_act && !r_s1_pix) || (s1_run_on && r_s1_lc);
    end

    assign wr_rh_en   = i_ctl.advance && (s1_start || s1_col_inc);
    assign wr_rh_data = s1_start ? {r_s1_r, RHW'(1)} : {rd_row, s1_h_inc};
    assign wr_w_en    = i_ctl.advance && s1_rclose;

    // line state, cleared when the image ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= '0;
            r_upper   <= '0;
            r_left    <= 1'b0;
            r_run_act <= 1'b0;
        end else if (i_ctl.advance) begin
            if (o_last) begin
                r_act     <= '0;
                r_upper   <= '0;
                r_left    <= 1'b0;
                r_run_act <= 1'b0;
            end else begin
                r_act[r_s1_c]   <= s1_start || (s1_act && r_s1_pix);
                r_upper[r_s1_c] <= r_s1_pix;
                r_left          <= r_s1_pix;
                r_run_act       <= s1_run_on && !r_s1_lc;
            end
        end
    end

    // open run payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_run_w <= s1_run_w;
            r_run_c <= s1_run_c;
        end
    end

    // candidates; an empty one is zero and never wins
    always_comb begin
        o_w_val = '0;
        o_w_row = '0;
        o_w_col = '0;
        o_b_val = '0;
        o_b_row = '0;
        o_b_col = '0;
        if (s1_rclose) begin
            o_w_val = s1_run_w;
            o_w_row = r_s1_r;
            o_w_col = s1_run_c;
            o_b_val = AW'(s1_run_w);
            o_b_row = r_s1_r;
            o_b_col = s1_run_c;
        end
        o_h_val = '0;
        o_h_row = '0;
        o_h_col = '0;
        o_a_val = '0;
        o_a_row = '0;
        o_a_col = '0;
        if (s1_start) begin
            o_h_val = RHW'(1);
            o_h_row = r_s1_r;
            o_h_col = r_s1_c;
        end else if (s1_col_inc) begin
            o_h_val = s1_h_inc;
            o_h_row = rd_row;
            o_h_col = r_s1_c;
            o_a_val = s1_area;
            o_a_row = rd_row;
            o_a_col = r_s1_c;
        end
    end

endmodule

[sv/bremx_best.sv]
// ----------------------------------------------------------------------------
// bremx_best
// running best of one measure; larger value wins, then earlier corner
// ----------------------------------------------------------------------------
module bremx_best
    import bremx_pkg::*;
#(
    parameter int VW = 7,
    parameter int RW = 6,
    parameter int CW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_best_ctl     i_ctl,
    input  logic [VW-1:0] i_a_val,
    input  logic [RW-1:0] i_a_row,
    input  logic [CW-1:0] i_a_col,
    input  logic [VW-1:0] i_b_val,
    input  logic [RW-1:0] i_b_row,
    input  logic [CW-1:0] i_b_col,
    output logic [VW-1:0] o_val,
    output logic [RW-1:0] o_row,
    output logic [CW-1:0] o_col
);

    localparam int KW = VW + RW + CW;

    logic [VW-1:0] r_a_val;
    logic [RW-1:0] r_a_row;
    logic [CW-1:0] r_a_col;
    logic [VW-1:0] r_b_val;
    logic [RW-1:0] r_b_row;
    logic [CW-1:0] r_b_col;
    logic [VW-1:0] r_best_val;
    logic [RW-1:0] r_best_row;
    logic [CW-1:0] r_best_col;

    logic [KW-1:0] a_key;
    logic [KW-1:0] b_key;
    logic [KW-1:0] best_key;
    logic          a_over_b;
    logic          a_over_best;
    logic          b_over_best;

    // candidate stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a_val <= i_a_val;
            r_a_row <= i_a_row;
            r_a_col <= i_a_col;
            r_b_val <= i_b_val;
            r_b_row <= i_b_row;
            r_b_col <= i_b_col;
        end
    end

    // inverted corner bits make one compare give value, row, column order
    assign a_key    = {r_a_val, ~r_a_row, ~r_a_col};
    assign b_key    = {r_b_val, ~r_b_row, ~r_b_col};
    assign best_key = {r_best_val, ~r_best_row, ~r_best_col};

    assign a_over_b    = a_key > b_key;
    assign a_over_best = a_key > best_key;
    assign b_over_best = b_key > best_key;

    // winner of the three
    always_comb begin
        if (a_over_b && a_over_best) begin
            o_val = r_a_val;
            o_row = r_a_row;
            o_col = r_a_col;
        end else if (!a_over_b && b_over_best) begin
            o_val = r_b_val;
            o_row = r_b_row;
            o_col = r_b_col;
        end else begin
            o_val = r_best_val;
            o_row = r_best_row;
            o_col = r_best_col;
        end
    end

    // best register, restarts after the image result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_val <= '0;
            r_best_row <= '0;
            r_best_col <= '0;
        end else if (i_ctl.update) begin
            if (i_ctl.flush) begin
                r_best_val <= '0;
                r_best_row <= '0;
                r_best_col <= '0;
            end else begin
                r_best_val <= o_val;
                r_best_row <= o_row;
                r_best_col <= o_col;
            end
        end
    end

endmodule

[sv/binary_rectangle_extent_max.sv]
// ----------------------------------------------------------------------------
// binary_rectangle_extent_max
// widest, tallest and largest rectangle extent of a raster binary image
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on i_pixel, one per beat, in raster order, under
//   i_in_valid / o_in_ready. The image size comes from the row and column
//   count registers, written through i_cfg_we / i_cfg_index / i_cfg_data
//   while no image result is pending; both reset to 64.
//   Only the last pixel of an image yields a beat on the output channel
//   (o_out_valid / i_out_ready): the largest width, height and area with
//   their corner positions, all zero when the image had no set pixel.
//   Throughput is one pixel per cycle unless stalled; a pixel touches one
//   column entry and the run registers, and the column state sits in a
//   memory whose read is issued as the pixel is accepted. o_out_valid rises
//   once the last pixel has passed stage one, stage two and the result
//   register. While the result waits, pixels of the next image still flow;
//   a second finished image stalls o_in_ready until the result is taken.
//   Reset empties the pipeline, clears all image state and restores both
//   counts; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_rectangle_extent_max
    import bremx_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_WID_W-1:0]  o_max_width,
    output logic [OUT_POS_W-1:0]  o_width_row,
    output logic [OUT_POS_W-1:0]  o_width_col,
    output logic [OUT_HGT_W-1:0]  o_max_height,
    output logic [OUT_POS_W-1:0]  o_height_row,
    output logic [OUT_POS_W-1:0]  o_height_col,
    output logic [OUT_AREA_W-1:0] o_max_area,
    output logic [OUT_POS_W-1:0]  o_area_row,
    output logic [OUT_POS_W-1:0]  o_area_col
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RHW = $clog2(MAX_ROWS + 1);
    localparam int CHW = $clog2(MAX_COLS + 1);
    localparam int AW  = $clog2(MAX_ROWS * MAX_COLS + 1);

    logic [CFG_W-1:0] r_row_count;
    logic [CFG_W-1:0] r_col_count;

    logic r_s1_vld;
    logic r_s2_vld;
    logic r_s2_last;
    logic r_out_vld;

    logic out_free;
    logic s2_adv;
    logic s1_adv;
    logic in_acc;
    logic s1_last;

    t_pipe_ctl pipe_ctl;
    t_best_ctl best_ctl;

    logic [CHW-1:0] w_val;
    logic [RW-1:0]  w_row;
    logic [CW-1:0]  w_col;
    logic [RHW-1:0] h_val;
    logic [RW-1:0]  h_row;
    logic [CW-1:0]  h_col;
    logic [AW-1:0]  a_val;
    logic [RW-1:0]  a_row;
    logic [CW-1:0]  a_col;
    logic [AW-1:0]  b_val;
    logic [RW-1:0]  b_row;
    logic [CW-1:0]  b_col;

    logic [CHW-1:0] bw_val;
    logic [RW-1:0]  bw_row;
    logic [CW-1:0]  bw_col;
    logic [RHW-1:0] bh_val;
    logic [RW-1:0]  bh_row;
    logic [CW-1:0]  bh_col;
    logic [AW-1:0]  ba_val;
    logic [RW-1:0]  ba_row;
    logic [CW-1:0]  ba_col;

    logic [CHW-1:0] r_ow_val;
    logic [RW-1:0]  r_ow_row;
    logic [CW-1:0]  r_ow_col;
    logic [RHW-1:0] r_oh_val;
    logic [RW-1:0]  r_oh_row;
    logic [CW-1:0]  r_oh_col;
    logic [AW-1:0]  r_oa_val;
    logic [RW-1:0]  r_oa_row;
    logic [CW-1:0]  r_oa_col;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CNT_RST;
            r_col_count <= CNT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ROW_COUNT: r_row_count <= i_cfg_data;
                REG_COL_COUNT: r_col_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow: only an image result can hold stage two
    assign out_free   = !r_out_vld || i_out_ready;
    assign s2_adv     = r_s2_vld && (!r_s2_last || out_free);
    assign s1_adv     = r_s1_vld && (!r_s2_vld || s2_adv);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    assign pipe_ctl = '{accept: in_acc, advance: s1_adv};
    assign best_ctl = '{load: s1_adv, update: s2_adv, flush: s2_adv && r_s2_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s2_last <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= in_acc || (r_s1_vld && !s1_adv);
            r_s2_vld  <= s1_adv || (r_s2_vld && !s2_adv);
            if (s1_adv) begin
                r_s2_last <= s1_last;
            end
            r_out_vld <= best_ctl.flush || (r_out_vld && !i_out_ready);
        end
    end

    // pixel tracking
    bremx_track #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_count (r_row_count),
        .i_col_count (r_col_count),
        .i_ctl       (pipe_ctl),
        .i_pixel     (i_pixel),
        .o_last      (s1_last),
        .o_w_val     (w_val),
        .o_w_row     (w_row),
        .o_w_col     (w_col),
        .o_h_val     (h_val),
        .o_h_row     (h_row),
        .o_h_col     (h_col),
        .o_a_val     (a_val),
        .o_a_row     (a_row),
        .o_a_col     (a_col),
        .o_b_val     (b_val),
        .o_b_row     (b_row),
        .o_b_col     (b_col)
    );

    // running bests
    bremx_best #(.VW(CHW), .RW(RW), .CW(CW)) u_best_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (best_ctl),
        .i_a_val (w_val),
        .i_a_row (w_row),
        .i_a_col (w_col),
        .i_b_val ('0),
        .i_b_row ('0),
        .i_b_col ('0),
        .o_val   (bw_val),
        .o_row   (bw_row),
        .o_col   (bw_col)
    );

    bremx_best #(.VW(RHW), .RW(RW), .CW(CW)) u_best_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (best_ctl),
        .i_a_val (h_val),
        .i_a_row (h_row),
        .i_a_col (h_col),
        .i_b_val ('0),
        .i_b_row ('0),
        .i_b_col ('0),
        .o_val   (bh_val),
        .o_row   (bh_row),
        .o_col   (bh_col)
    );

    bremx_best #(.VW(AW), .RW(RW), .CW(CW)) u_best_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (best_ctl),
        .i_a_val (a_val),
        .i_a_row (a_row),
        .i_a_col (a_col),
        .i_b_val (b_val),
        .i_b_row (b_row),
        .i_b_col (b_col),
        .o_val   (ba_val),
        .o_row   (ba_row),
        .o_col   (ba_col)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (best_ctl.flush) begin
            r_ow_val <= bw_val;
            r_ow_row <= bw_row;
            r_ow_col <= bw_col;
            r_oh_val <= bh_val;
            r_oh_row <= bh_row;
            r_oh_col <= bh_col;
            r_oa_val <= ba_val;
            r_oa_row <= ba_row;
            r_oa_col <= ba_col;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_max_width  = OUT_WID_W'(r_ow_val);
    assign o_width_row  = OUT_POS_W'(r_ow_row);
    assign o_width_col  = OUT_POS_W'(r_ow_col);
    assign o_max_height = OUT_HGT_W'(r_oh_val);
    assign o_height_row = OUT_POS_W'(r_oh_row);
    assign o_height_col = OUT_POS_W'(r_oh_col);
    assign o_max_area   = OUT_AREA_W'(r_oa_val);
    assign o_area_row   = OUT_POS_W'(r_oa_row);
    assign o_area_col   = OUT_POS_W'(r_oa_col);

endmodule

[sv/bremx_checker.sv]
// ----------------------------------------------------------------------------
// bremx_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "binary_rectangle_extent_max_macros.svh"

module bremx_checker
    import bremx_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [OUT_WID_W-1:0]  o_max_width,
    input logic [OUT_POS_W-1:0]  o_width_row,
    input logic [OUT_POS_W-1:0]  o_width_col,
    input logic [OUT_HGT_W-1:0]  o_max_height,
    input logic [OUT_POS_W-1:0]  o_height_row,
    input logic [OUT_POS_W-1:0]  o_height_col,
    input logic [OUT_AREA_W-1:0] o_max_area,
    input logic [OUT_POS_W-1:0]  o_area_row,
    input logic [OUT_POS_W-1:0]  o_area_col
);

    localparam int PW = OUT_WID_W + OUT_HGT_W;

    logic [PW-1:0] wh_prod;

    assign wh_prod = PW'(o_max_width) * PW'(o_max_height);

    // a stalled result beat stays up
    `BREMX_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready && i_rst_n, o_out_valid, "result beat dropped while stalled")

    // a stalled result beat keeps its area
    `BREMX_ASSERT_NXT(a_out_stable, o_out_valid && !i_out_ready && i_rst_n, $stable(o_max_area), "result area changed while stalled")

    // the best area never exceeds best width times best height
    `BREMX_ASSERT_IMP(a_area_bound, o_out_valid, PW'(o_max_area) <= wh_prod, "area above width times height")

    // no area means no region at all
    `BREMX_ASSERT_IMP(a_empty_zero, o_out_valid && (o_max_area == '0), (o_max_width == '0) && (o_max_height == '0) && (o_width_row == '0) && (o_width_col == '0) && (o_height_row == '0) && (o_height_col == '0) && (o_area_row == '0) && (o_area_col == '0), "empty image with nonzero fields")

endmodule

bind binary_rectangle_extent_max bremx_checker u_bremx_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_max_width  (o_max_width),
    .o_width_row  (o_width_row),
    .o_width_col  (o_width_col),
    .o_max_height (o_max_height),
    .o_height_row (o_height_row),
    .o_height_col (o_height_col),
    .o_max_area   (o_max_area),
    .o_area_row   (o_area_row),
    .o_area_col   (o_area_col)
);
